// ===== rtl/core/wllc_pkg.sv =====
// ----------------------------------------------------------------------------
// wllc_pkg
// shared types and op codes for the weighted lru/lfu slot cache
// ----------------------------------------------------------------------------
package wllc_pkg;

    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_LOOKUP_PIN = 3'd1,
        OP_CLEAR_PINS = 3'd2,
        OP_TICK       = 3'd3,
        OP_TOUCH      = 3'd4
    } op_t;

    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_MISS = 2'd1;
    localparam logic [1:0] OUT_NONE = 2'd2;

    localparam int KEY_W  = 18;
    localparam int USES_W = 32;
    localparam int REC_W  = 27;

    localparam logic [3:0] CFG_WEIGHT = 4'd0;
    localparam logic [3:0] CFG_LIMIT  = 4'd1;

    localparam logic [REC_W-1:0] REC_AT_ZERO = REC_W'(1000 << 16);

endpackage

// ===== rtl/core/wllc_div.sv =====
// ----------------------------------------------------------------------------
// wllc_div
// restoring divider for 65536 / age, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wllc_div #(
    parameter int TICK_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TICK_BITS-1:0]          divisor,
    output logic                          done,
    output logic [wllc_pkg::REC_W-1:0]    quotient
);
    import wllc_pkg::*;

    localparam int NB = 17;
    localparam int CW = $clog2(NB + 1);

    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [NB-1:0]        num_reg;
    logic [TICK_BITS:0]   rem_reg;
    logic [NB-1:0]        q_reg;
    logic [TICK_BITS-1:0] den_reg;
    logic [TICK_BITS:0]   trial;

    assign trial = {rem_reg[TICK_BITS-1:0], num_reg[NB-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                num_reg  <= NB'(65536);
                rem_reg  <= '0;
                den_reg  <= divisor;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[NB-2:0], 1'b0};
                if (!trial[TICK_BITS])
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[TICK_BITS-1:0], num_reg[NB-1]};
                    q_reg   <= {q_reg[NB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = {{(REC_W-NB){1'b0}}, q_reg};

endmodule

// ===== rtl/core/weighted_lru_lfu_slot_cache_top.sv =====
// ----------------------------------------------------------------------------
// weighted_lru_lfu_slot_cache_top
// fully associative slot cache with a hybrid recency/frequency victim choice
// ----------------------------------------------------------------------------
// a hit ends the tag search at its slot; a miss searches every slot, then walks
//   them for a victim (pinned slots skipped, an empty slot taken at once, age zero
//   scored without the bit-serial 65536/age divide), rereads it and writes the slot
// one word at a time; clear pins and tick touch no memory, touch reads then writes
// reset: control state clears at once, then a clearing pass over all NUM_SLOTS
//   slots zeros the slot memory; no word is accepted during it
// ----------------------------------------------------------------------------
module weighted_lru_lfu_slot_cache_top #(
    parameter int NUM_SLOTS = 64,
    parameter int TICK_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [7:0]  req_layer,
    input  logic [7:0]  req_expert,
    input  logic [1:0]  proj_kind,
    input  logic [5:0]  touch_slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic [5:0]  result_slot,
    output logic        evicted,
    output logic [7:0]  old_layer,
    output logic [7:0]  old_expert,
    output logic [1:0]  old_proj
);
    import wllc_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = AW + 1;
    localparam int EW = 1 + KEY_W + TICK_BITS + USES_W;

    // entry layout: valid, key, last tick, uses (pins live in flip-flops)
    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [TICK_BITS-1:0] last;
        logic [USES_W-1:0]    uses;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SRD, S_SCHK, S_VRD, S_VCHK, S_VDIV, S_VMUL,
        S_VSUM, S_FRD, S_FCHK, S_WRITE, S_TRD, S_TWR, S_OUT
    } state_t;

    // slot memory
    entry_t              mem [NUM_SLOTS];
    entry_t              rd_data_reg;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    entry_t              wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    logic [NUM_SLOTS-1:0] pin_reg;
    logic [16:0]          weight_reg;
    logic [8:0]           limit_reg;
    logic [TICK_BITS-1:0] tick_reg;
    state_t               state_reg;
    logic [CW-1:0]        idx_reg;
    logic [2:0]           op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [AW-1:0]        best_reg;
    logic                 have_reg;
    logic                 found_reg;
    logic                 div_run_reg;
    logic [63:0]          best_score_reg;
    entry_t               cur_reg;
    logic [REC_W-1:0]     rec_reg;
    logic [43:0]          prod_a_reg;
    logic [48:0]          prod_b_reg;
    logic                 hit_reg;
    logic                 div_start;
    logic                 div_done;
    logic [REC_W-1:0]     div_q;
    logic [TICK_BITS-1:0] age;
    logic [63:0]          score;
    logic [16:0]          wsat;
    logic                 res_valid_reg;
    logic [1:0]           res_outcome_reg;
    logic [5:0]           res_slot_reg;
    logic                 res_ev_reg;
    logic [KEY_W-1:0]     res_old_reg;

    wllc_div #(.TICK_BITS(TICK_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(age),
        .done(div_done), .quotient(div_q)
    );

    assign wsat  = weight_reg[16] ? 17'd65536 : weight_reg;
    assign age   = tick_reg - cur_reg.last;
    assign score = 64'(prod_a_reg >> 16) + 64'(prod_b_reg);
    // one start pulse on entry to the divide state, only for a nonzero age
    assign div_start = (state_reg == S_VDIV) && !div_run_reg && (age != '0);

    // read address follows the walking index, the final reread takes the victim
    assign raddr = (state_reg == S_FRD) ? best_reg : idx_reg[AW-1:0];
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = '0;
        case (state_reg)
            S_CLEAR: we = 1'b1;
            S_WRITE:
            begin
                we    = 1'b1;
                waddr = best_reg;
                if (hit_reg)
                begin
                    wdata      = cur_reg;
                    wdata.last = tick_reg;
                    if (cur_reg.uses != '1)
                        wdata.uses = cur_reg.uses + 1'b1;
                end
                else
                begin
                    wdata.valid = 1'b1;
                    wdata.key   = key_reg;
                    wdata.last  = tick_reg;
                    wdata.uses  = USES_W'(1);
                end
            end
            S_TWR:
            begin
                we         = 1'b1;
                waddr      = best_reg;
                wdata      = rd_data_reg;
                wdata.last = tick_reg;
                if (rd_data_reg.uses != '1)
                    wdata.uses = rd_data_reg.uses + 1'b1;
            end
            default: we = 1'b0;
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE) || res_valid_reg;
    assign out_valid   = res_valid_reg;
    assign outcome     = res_outcome_reg;
    assign result_slot = res_slot_reg;
    assign evicted     = res_ev_reg;
    assign old_layer   = res_old_reg[7:0];
    assign old_expert  = res_old_reg[15:8];
    assign old_proj    = res_old_reg[17:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            pin_reg       <= '0;
            weight_reg    <= 17'd32768;
            limit_reg     <= 9'd256;
            tick_reg      <= '0;
            res_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            div_run_reg   <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_WEIGHT)
                weight_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_LIMIT)
                limit_reg <= cfg_data[8:0];
            if (res_valid_reg && !out_stall)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == CW'(NUM_SLOTS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        op_reg          <= op;
                        key_reg         <= {proj_kind, req_expert, req_layer};
                        // touch walks straight to its slot, lookups start at 0
                        idx_reg         <= (op == OP_TOUCH) ? CW'(touch_slot) : CW'(0);
                        best_reg        <= (op == OP_TOUCH) ? AW'(touch_slot) : AW'(0);
                        have_reg        <= 1'b0;
                        found_reg       <= 1'b0;
                        hit_reg         <= 1'b0;
                        res_outcome_reg <= OUT_NONE;
                        res_slot_reg    <= '0;
                        res_ev_reg      <= 1'b0;
                        res_old_reg     <= '0;
                        case (op)
                            OP_LOOKUP: state_reg <= S_SRD;
                            OP_LOOKUP_PIN:
                                if ({1'b0, req_layer} >= limit_reg)
                                    state_reg <= S_OUT;
                                else
                                    state_reg <= S_SRD;
                            OP_CLEAR_PINS:
                            begin
                                pin_reg   <= '0;
                                state_reg <= S_OUT;
                            end
                            OP_TICK:
                            begin
                                tick_reg  <= tick_reg + 1'b1;
                                state_reg <= S_OUT;
                            end
                            OP_TOUCH:
                                if (32'(touch_slot) < NUM_SLOTS)
                                    state_reg <= S_TRD;
                                else
                                    state_reg <= S_OUT;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                S_TRD: state_reg <= S_TWR;
                S_TWR: state_reg <= S_OUT;
                S_SRD: state_reg <= S_SCHK;
                S_SCHK:
                    if (rd_data_reg.valid && rd_data_reg.key == key_reg)
                    begin
                        hit_reg   <= 1'b1;
                        best_reg  <= idx_reg[AW-1:0];
                        cur_reg   <= rd_data_reg;
                        state_reg <= S_WRITE;
                    end
                    else if (idx_reg == CW'(NUM_SLOTS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                S_VRD: state_reg <= S_VCHK;
                S_VCHK:
                    if (pin_reg[idx_reg[AW-1:0]])
                        state_reg <= S_VSUM;
                    else if (!rd_data_reg.valid)
                    begin
                        best_reg  <= idx_reg[AW-1:0];
                        cur_reg   <= rd_data_reg;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        cur_reg   <= rd_data_reg;
                        state_reg <= S_VDIV;
                    end
                S_VDIV:
                    if (age == '0)
                    begin
                        rec_reg   <= REC_AT_ZERO;
                        state_reg <= S_VMUL;
                    end
                    else if (div_done)
                    begin
                        rec_reg     <= div_q;
                        div_run_reg <= 1'b0;
                        state_reg   <= S_VMUL;
                    end
                    else
                        div_run_reg <= 1'b1;
                S_VMUL:
                begin
                    prod_a_reg <= 44'(wsat) * 44'(rec_reg);
                    prod_b_reg <= 49'(17'd65536 - wsat) * 49'(cur_reg.uses);
                    have_reg   <= 1'b1;
                    state_reg  <= S_VSUM;
                end
                S_VSUM:
                begin
                    // have_reg marks a fresh score from this slot, lowest index wins ties
                    if (have_reg && (!found_reg || score < best_score_reg))
                    begin
                        best_score_reg <= score;
                        best_reg       <= idx_reg[AW-1:0];
                        found_reg      <= 1'b1;
                    end
                    have_reg <= 1'b0;
                    if (idx_reg == CW'(NUM_SLOTS - 1))
                        state_reg <= S_FRD;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_VRD;
                    end
                end
                // reread the chosen victim, slot 0 when every slot is pinned
                S_FRD: state_reg <= S_FCHK;
                S_FCHK:
                begin
                    cur_reg   <= rd_data_reg;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    res_outcome_reg <= hit_reg ? OUT_HIT : OUT_MISS;
                    res_slot_reg    <= 6'(best_reg);
                    if (!hit_reg && cur_reg.valid)
                    begin
                        res_ev_reg  <= 1'b1;
                        res_old_reg <= cur_reg.key;
                    end
                    else
                        res_ev_reg <= 1'b0;
                    if (op_reg == OP_LOOKUP_PIN)
                        pin_reg[best_reg] <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // one word in flight at a time
    property p_one_word;
        @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
    endproperty
    a_one_word: assert property (p_one_word) else $error("input open while result waits");

    property p_clear_stall;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_CLEAR) |-> in_stall;
    endproperty
    a_clear_stall: assert property (p_clear_stall) else $error("accept during clear");

    property p_out_after;
        @(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(state_reg == S_OUT);
    endproperty
    a_out_after: assert property (p_out_after) else $error("result without finish");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the weighted lru/lfu slot cache: words go in
// through a queue-fed driver, an internal predictor of the slot state works
// out each expected result, and a monitor compares every result field by field
// ----------------------------------------------------------------------------
module tb_top;
    import wllc_pkg::*;

    localparam int NSLOT     = 64;
    localparam int WATCHDOG  = 40000;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] layer;
        logic [7:0] expert;
        logic [1:0] proj;
        logic [5:0] tslot;
    } req_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [5:0] slot;
        logic       evicted;
        logic [7:0] old_layer;
        logic [7:0] old_expert;
        logic [1:0] old_proj;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [7:0]  req_layer;
    logic [7:0]  req_expert;
    logic [1:0]  proj_kind;
    logic [5:0]  touch_slot;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  outcome;
    logic [5:0]  result_slot;
    logic        evicted;
    logic [7:0]  old_layer;
    logic [7:0]  old_expert;
    logic [1:0]  old_proj;

    weighted_lru_lfu_slot_cache_top dut (.*);

    // predictor state: a private copy of the cache
    logic [16:0] weight_reg;
    logic [8:0]  limit_reg;
    logic [31:0] now_tick;
    logic        v_q   [NSLOT];
    logic        pin_q [NSLOT];
    logic [17:0] key_q [NSLOT];
    logic [31:0] last_q[NSLOT];
    logic [31:0] uses_q[NSLOT];

    req_t  word_q[$];
    resp_t expected_q[$];
    int    errors;
    int    sent;
    int    got;
    int    idle_cycles;
    int    hits, misses, evicts;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void bump(int s);
        last_q[s] = now_tick;
        if (uses_q[s] != 32'hffff_ffff)
            uses_q[s] = uses_q[s] + 1;
    endfunction

    function automatic logic [63:0] evict_score(int s);
        logic [63:0] w;
        logic [31:0] age;
        logic [63:0] rec;
        w = (weight_reg > 17'd65536) ? 64'd65536 : 64'(weight_reg);
        age = now_tick - last_q[s];
        rec = (age == 0) ? 64'(1000 << 16) : 64'd65536 / 64'(age);
        return ((w * rec) >> 16) + (64'd65536 - w) * 64'(uses_q[s]);
    endfunction

    function automatic int choose_victim();
        int best;
        bit have;
        logic [63:0] best_sc;
        logic [63:0] sc;
        best = 0;
        have = 0;
        best_sc = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (pin_q[i])
                continue;
            if (!v_q[i])
                return i;
            sc = evict_score(i);
            if (!have || sc < best_sc) begin
                have = 1;
                best_sc = sc;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic resp_t cache_access(req_t r);
        resp_t e;
        logic [17:0] k;
        int s;
        bit hit;
        e = '0;
        e.outcome = OUT_NONE;
        k = {r.proj, r.expert, r.layer};
        s = 0;
        hit = 0;
        case (r.op)
            OP_CLEAR_PINS: begin
                for (int i = 0; i < NSLOT; i++)
                    pin_q[i] = 0;
                return e;
            end
            OP_TICK: begin
                now_tick = now_tick + 1;
                return e;
            end
            OP_TOUCH: begin
                bump(int'(r.tslot));
                return e;
            end
            OP_LOOKUP, OP_LOOKUP_PIN: ;
            default: return e;
        endcase
        if (r.op == OP_LOOKUP_PIN && {1'b0, r.layer} >= limit_reg)
            return e;
        for (int i = 0; i < NSLOT; i++) begin
            if (v_q[i] && key_q[i] == k) begin
                s = i;
                hit = 1;
                break;
            end
        end
        if (hit) begin
            bump(s);
            e.outcome = OUT_HIT;
        end else begin
            s = choose_victim();
            e.outcome = OUT_MISS;
            if (v_q[s]) begin
                e.evicted = 1;
                {e.old_proj, e.old_expert, e.old_layer} = key_q[s];
            end
            v_q[s] = 1;
            key_q[s] = k;
            last_q[s] = now_tick;
            uses_q[s] = 1;
        end
        e.slot = 6'(s);
        if (r.op == OP_LOOKUP_PIN)
            pin_q[s] = 1;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        // mostly back to back, some short gaps, a few long ones
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver: pulls words from the queue, predicts at acceptance
    // ------------------------------------------------------------------
    int   in_gap;
    int   issued = 0;
    req_t cur;

    always @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            expected_q.insert(expected_q.size(), cache_access(cur));
            sent <= sent + 1;
        end
    end

    // a word is still pending until the accept count catches up with it
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 0;
            in_gap = 0;
        end else if (in_valid && sent != issued) begin
            // hold the stalled word
        end else if (in_gap > 0) begin
            in_gap = in_gap - 1;
            in_valid <= 0;
        end else if (word_q.size() > 0) begin
            cur = word_q.pop_front();
            op <= cur.op;
            req_layer <= cur.layer;
            req_expert <= cur.expert;
            proj_kind <= cur.proj;
            touch_slot <= cur.tslot;
            in_valid <= 1;
            issued = issued + 1;
            in_gap = pick_gap();
        end else begin
            in_valid <= 0;
        end
    end

    // random back-pressure on the result side
    int out_hold;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold = out_hold - 1;
            out_stall <= 1;
        end else begin
            out_stall <= 0;
            if ($urandom_range(0, 9) < 3)
                out_hold = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && !out_stall) begin
            got <= got + 1;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (outcome === OUT_HIT) hits++;
                if (outcome === OUT_MISS) misses++;
                if (evicted === 1'b1) evicts++;
                if (outcome !== e.outcome) begin
                    $error("outcome exp %0d got %0d", e.outcome, outcome); errors++;
                end
                if (result_slot !== e.slot) begin
                    $error("result_slot exp %0d got %0d", e.slot, result_slot); errors++;
                end
                if (evicted !== e.evicted) begin
                    $error("evicted exp %0d got %0d", e.evicted, evicted); errors++;
                end
                if (old_layer !== e.old_layer) begin
                    $error("old_layer exp %0d got %0d", e.old_layer, old_layer); errors++;
                end
                if (old_expert !== e.old_expert) begin
                    $error("old_expert exp %0d got %0d", e.old_expert, old_expert);
                    errors++;
                end
                if (old_proj !== e.old_proj) begin
                    $error("old_proj exp %0d got %0d", e.old_proj, old_proj); errors++;
                end
            end
        end
    end

    // watchdog: cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d results outstanding", expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic req_t mk(logic [2:0] o, logic [7:0] l, logic [7:0] x,
                                logic [1:0] p, logic [5:0] t);
        req_t r;
        r.op = o; r.layer = l; r.expert = x; r.proj = p; r.tslot = t;
        return r;
    endfunction

    // keys drawn from a small pool so hits and evictions both happen
    function automatic req_t rand_word(int pool);
        req_t r;
        int p;
        r = mk(3'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 6'($urandom));
        if ($urandom_range(0, 99) < 80) begin
            r.layer  = 8'($urandom_range(0, pool - 1));
            r.expert = 8'($urandom_range(0, 3));
            r.proj   = 2'($urandom_range(0, 2));
        end
        p = $urandom_range(0, 99);
        if (p < 55)      r.op = OP_LOOKUP;
        else if (p < 70) r.op = OP_LOOKUP_PIN;
        else if (p < 75) r.op = OP_CLEAR_PINS;
        else if (p < 88) r.op = OP_TICK;
        else if (p < 96) r.op = OP_TOUCH;
        else             r.op = 3'($urandom_range(5, 7));
        return r;
    endfunction

    task automatic cfg_write(logic [3:0] idx, logic [16:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_WEIGHT) weight_reg = val;
        else if (idx == CFG_LIMIT) limit_reg = val[8:0];
    endtask

    task automatic wait_idle();
        while (word_q.size() > 0 || expected_q.size() > 0 || in_valid)
            @(posedge clk);
        // a word yields a result always, but let the block settle anyway
        repeat (200) @(posedge clk);
    endtask

    task automatic run_phase(int n, int pool);
        for (int i = 0; i < n; i++)
            word_q.insert(word_q.size(), rand_word(pool));
        wait_idle();
    endtask

    task automatic add_word(req_t r);
        word_q.insert(word_q.size(), r);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0; cfg_index = 0; cfg_data = 0;
        op = 0; req_layer = 0; req_expert = 0; proj_kind = 0; touch_slot = 0;
        errors = 0; sent = 0; got = 0; idle_cycles = 0;
        hits = 0; misses = 0; evicts = 0;
        weight_reg = 17'd32768;
        limit_reg = 9'd256;
        now_tick = 0;
        for (int i = 0; i < NSLOT; i++) begin
            v_q[i] = 0; pin_q[i] = 0; key_q[i] = 0; last_q[i] = 0; uses_q[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, every op, the special cases
        add_word(mk(OP_LOOKUP, 8'h00, 8'h00, 2'd0, 6'd0));
        add_word(mk(OP_LOOKUP, 8'hff, 8'hff, 2'd3, 6'd63));  // projection code 3
        add_word(mk(OP_LOOKUP, 8'hff, 8'hff, 2'd3, 6'd0));   // hit
        add_word(mk(OP_LOOKUP_PIN, 8'h12, 8'h34, 2'd2, 6'd0));
        add_word(mk(OP_TICK, 8'h00, 8'h00, 2'd0, 6'd0));
        add_word(mk(OP_TOUCH, 8'h00, 8'h00, 2'd0, 6'd0));
        add_word(mk(OP_TOUCH, 8'h00, 8'h00, 2'd0, 6'd63));   // empty slot touched
        add_word(mk(3'd5, 8'haa, 8'h55, 2'd1, 6'd21));       // unused op codes
        add_word(mk(3'd6, 8'h55, 8'haa, 2'd2, 6'd42));
        add_word(mk(3'd7, 8'hff, 8'hff, 2'd3, 6'd63));
        add_word(mk(OP_CLEAR_PINS, 8'h00, 8'h00, 2'd0, 6'd0));
        wait_idle();

        // pin limit: layer at the limit is ignored, below it pins
        cfg_write(CFG_LIMIT, 17'd1);
        add_word(mk(OP_LOOKUP_PIN, 8'h01, 8'h01, 2'd1, 6'd0));
        add_word(mk(OP_LOOKUP_PIN, 8'h00, 8'h07, 2'd1, 6'd0));
        wait_idle();

        // all slots pinned: fill every slot with pins, then two more pin lookups and a plain lookup that miss
        cfg_write(CFG_LIMIT, 17'd256);
        for (int i = 0; i < NSLOT + 2; i++)
            add_word(mk(OP_LOOKUP_PIN, 8'(i), 8'h80, 2'd0, 6'(i)));
        add_word(mk(OP_LOOKUP, 8'h99, 8'h99, 2'd1, 6'd0));
        add_word(mk(OP_CLEAR_PINS, 8'h00, 8'h00, 2'd0, 6'd0));
        wait_idle();

        // random phases under several weights, extremes included
        cfg_write(CFG_WEIGHT, 17'd65536);  // pure recency
        run_phase(160, 80);
        cfg_write(CFG_WEIGHT, 17'd0);      // pure frequency
        cfg_write(CFG_LIMIT, 17'd40);
        run_phase(160, 90);
        cfg_write(CFG_WEIGHT, 17'h1ffff);  // above 1.0, saturates
        run_phase(140, 100);
        cfg_write(CFG_WEIGHT, 17'($urandom_range(1, 65535)));
        cfg_write(CFG_LIMIT, 17'($urandom_range(1, 255)));
        run_phase(160, 70);
        cfg_write(CFG_WEIGHT, 17'd32768);
        cfg_write(CFG_LIMIT, 17'd256);
        run_phase(160, 120);
        cfg_write(CFG_WEIGHT, 17'd1);
        run_phase(90, 256);

        $display("covered %0d words and %0d results, %0d hits, %0d misses, %0d evictions",
                 sent, got, hits, misses, evicts);
        $display("weights 0, 1, 0.5, 1.0, above 1.0 and random; pin limits 1 to 256");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
